// ----- hw/rtl/hbtq_pkg.sv -----
// shared types and constants of the heartbeat timer queue
package hbtq_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int MAX_RESULTS = 32;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int TIME_W = 32;
	localparam int CONN_W = 16;
	localparam int SEQ_W = 32;
	localparam int WAIT_W = 16;

	localparam logic [1:0] KIND_ADD = 2'd0;
	localparam logic [1:0] KIND_DEL = 2'd1;
	localparam logic [1:0] KIND_TICK = 2'd2;
	localparam logic [1:0] KIND_CLR = 2'd3;

	localparam logic [2:0] STAT_ADDED = 3'd0;
	localparam logic [2:0] STAT_FULL = 3'd1;
	localparam logic [2:0] STAT_DELETED = 3'd2;
	localparam logic [2:0] STAT_EXPIRED = 3'd3;
	localparam logic [2:0] STAT_NONE = 3'd4;
	localparam logic [2:0] STAT_CLEARED = 3'd5;

	localparam logic CFG_WAIT = 1'b0;
	localparam logic CFG_KICK = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_ADD, ST_DEL, ST_SCAN, ST_POP, ST_CLR
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE, OP_ADD, OP_DEL, OP_SCAN, OP_POP, OP_CLR
	} op_t;

	typedef struct packed {
		logic latch;
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic del_hit;
		logic scan_zero;
		logic pop_last;
	} stat_t;

	typedef struct packed {
		logic [TIME_W-1:0] expiry;
		logic [CONN_W-1:0] conn;
		logic [SEQ_W-1:0] seq;
	} entry_t;

endpackage

// ----- hw/rtl/hbtq_ctrl.sv -----
// sequencer of the heartbeat timer queue
module hbtq_ctrl import hbtq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [1:0] kind,
	input stat_t st,
	output cmd_t cmd,
	output logic busy
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.latch = 1'b0;
		cmd.op = OP_NONE;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.latch = 1'b1;
					unique case (kind)
						KIND_ADD: state_d = ST_ADD;
						KIND_DEL: state_d = ST_DEL;
						KIND_TICK: state_d = ST_SCAN;
						KIND_CLR: state_d = ST_CLR;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADD: begin
				cmd.op = OP_ADD;
				state_d = ST_IDLE;
			end
			ST_CLR: begin
				cmd.op = OP_CLR;
				state_d = ST_IDLE;
			end
			ST_DEL: begin
				cmd.op = OP_DEL;
				if (!st.del_hit) state_d = ST_IDLE;
			end
			ST_SCAN: begin
				cmd.op = OP_SCAN;
				state_d = st.scan_zero ? ST_IDLE : ST_POP;
			end
			ST_POP: begin
				cmd.op = OP_POP;
				if (st.pop_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ----- hw/rtl/hbtq_datapath.sv -----
// sorted entry chain, configuration and result registers
module hbtq_datapath import hbtq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cmd_t cmd,
	output stat_t st,
	input logic [CONN_W-1:0] conn_id,
	input logic [SEQ_W-1:0] sequence_req,
	input logic [TIME_W-1:0] now,
	input logic cfg_valid,
	input logic [0:0] cfg_index,
	input logic [WAIT_W-1:0] cfg_data,
	output logic done,
	output logic [2:0] status,
	output logic [CONN_W-1:0] out_conn,
	output logic [SEQ_W-1:0] out_sequence,
	output logic [TIME_W-1:0] out_expiry,
	output logic [CNT_W-1:0] removed_count,
	output logic [TIME_W-1:0] earliest,
	output logic [CNT_W-1:0] occupancy,
	output logic last
);

	entry_t ent_q [QUEUE_DEPTH];
	entry_t ent_d [QUEUE_DEPTH];
	entry_t sh [QUEUE_DEPTH];
	logic [CNT_W-1:0] count_q, count_d;
	logic [WAIT_W-1:0] wait_q;
	logic kick_q;
	logic [CONN_W-1:0] conn_q;
	logic [SEQ_W-1:0] seq_q;
	logic [TIME_W-1:0] now_q, due_q;
	logic [CNT_W-1:0] removed_q, pops_left_q, fin_occ_q;
	logic [TIME_W-1:0] fin_earliest_q;
	logic [TIME_W:0] due_sum;

	// combinational results of the chain
	logic del_hit;
	logic [CNT_W-1:0] expired;
	logic rest_valid;
	logic [TIME_W-1:0] rest_exp;
	logic [TIME_W-1:0] head_exp;

	logic emit;
	logic [2:0] r_status;
	logic [CONN_W-1:0] r_conn;
	logic [SEQ_W-1:0] r_seq;
	logic [TIME_W-1:0] r_exp, r_earliest;
	logic [CNT_W-1:0] r_removed, r_occ;
	logic r_last;

	assign due_sum = {1'b0, now} + {{(TIME_W + 1 - WAIT_W){1'b0}}, wait_q};
	assign head_exp = (count_q != '0) ? ent_q[0].expiry : '0;

	assign st.del_hit = del_hit;
	assign st.scan_zero = (expired == '0);
	assign st.pop_last = (pops_left_q == CNT_W'(1));

	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH - 1; i++) sh[i] = ent_q[i + 1];
		sh[QUEUE_DEPTH - 1] = ent_q[QUEUE_DEPTH - 1];
	end

	always_comb begin
		entry_t ins, prev;
		logic le, le_prev, run, match, prev_fz_le;
		logic [CNT_W-1:0] cnt_m1;

		for (int i = 0; i < QUEUE_DEPTH; i++) ent_d[i] = ent_q[i];
		count_d = count_q;
		del_hit = 1'b0;
		expired = '0;
		rest_valid = 1'b0;
		rest_exp = '0;
		emit = 1'b0;
		r_status = STAT_ADDED;
		r_conn = '0;
		r_seq = '0;
		r_exp = '0;
		r_removed = '0;
		r_earliest = '0;
		r_occ = '0;
		r_last = 1'b1;
		ins = '0;
		prev = '0;
		le = 1'b0;
		le_prev = 1'b1;
		run = 1'b0;
		match = 1'b0;
		prev_fz_le = 1'b1;
		cnt_m1 = count_q - CNT_W'(1);

		// scan of expired entries: the flags form a prefix since the chain is sorted
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			le = (CNT_W'(i) < count_q) && (ent_q[i].expiry <= now_q);
			if (le) expired = CNT_W'(i + 1);
			if (!le && prev_fz_le && (CNT_W'(i) < count_q)) begin
				rest_valid = 1'b1;
				rest_exp = ent_q[i].expiry;
			end
			prev_fz_le = le;
		end

		unique case (cmd.op)
			OP_ADD: begin
				emit = 1'b1;
				if (count_q == CNT_W'(QUEUE_DEPTH)) begin
					r_status = STAT_FULL;
					r_earliest = head_exp;
					r_occ = count_q;
				end else begin
					r_status = STAT_ADDED;
					ins = '{expiry: due_q, conn: conn_q, seq: seq_q};
					le_prev = 1'b1;
					for (int i = 0; i < QUEUE_DEPTH; i++) begin
						le = (CNT_W'(i) < count_q) && (ent_q[i].expiry <= due_q);
						if (le) ent_d[i] = ent_q[i];
						else if (le_prev) ent_d[i] = ins;
						else ent_d[i] = prev;
						prev = ent_q[i];
						le_prev = le;
					end
					count_d = count_q + CNT_W'(1);
					r_earliest = (count_q != '0 && ent_q[0].expiry <= due_q) ?
						ent_q[0].expiry : due_q;
					r_occ = count_d;
				end
			end
			OP_DEL: begin
				// remove the first matching entry each cycle
				for (int i = 0; i < QUEUE_DEPTH; i++) begin
					match = (CNT_W'(i) < count_q) && (ent_q[i].conn == conn_q);
					run = run | match;
					if (run) ent_d[i] = sh[i];
				end
				del_hit = run;
				if (run) begin
					count_d = cnt_m1;
				end else begin
					emit = 1'b1;
					r_status = STAT_DELETED;
					r_removed = removed_q;
					r_earliest = head_exp;
					r_occ = count_q;
				end
			end
			OP_SCAN: begin
				if (expired == '0) begin
					emit = 1'b1;
					r_status = STAT_NONE;
					r_earliest = head_exp;
					r_occ = count_q;
				end
			end
			OP_POP: begin
				emit = 1'b1;
				r_status = STAT_EXPIRED;
				r_conn = ent_q[0].conn;
				r_seq = ent_q[0].seq;
				r_exp = ent_q[0].expiry;
				r_earliest = fin_earliest_q;
				r_occ = fin_occ_q;
				r_last = (pops_left_q == CNT_W'(1));
				if (kick_q) begin
					for (int i = 0; i < QUEUE_DEPTH; i++) ent_d[i] = sh[i];
					count_d = cnt_m1;
				end else begin
					// drop the head and re-arm it in the same cycle
					ins = '{expiry: due_q, conn: ent_q[0].conn, seq: ent_q[0].seq};
					le_prev = 1'b1;
					for (int i = 0; i < QUEUE_DEPTH; i++) begin
						le = (CNT_W'(i) < cnt_m1) && (sh[i].expiry <= due_q);
						if (le) ent_d[i] = sh[i];
						else if (le_prev) ent_d[i] = ins;
						else ent_d[i] = ent_q[i];
						le_prev = le;
					end
				end
			end
			OP_CLR: begin
				emit = 1'b1;
				r_status = STAT_CLEARED;
				count_d = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			wait_q <= WAIT_W'(20);
			kick_q <= 1'b0;
			done <= 1'b0;
		end else begin
			count_q <= count_d;
			done <= emit;
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_WAIT: wait_q <= cfg_data;
					CFG_KICK: kick_q <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QUEUE_DEPTH; i++) ent_q[i] <= ent_d[i];
		if (cmd.latch) begin
			conn_q <= conn_id;
			seq_q <= sequence_req;
			now_q <= now;
			due_q <= due_sum[TIME_W] ? '1 : due_sum[TIME_W-1:0];
			removed_q <= '0;
		end
		if (cmd.op == OP_DEL && del_hit) removed_q <= removed_q + CNT_W'(1);
		if (cmd.op == OP_SCAN) begin
			pops_left_q <= expired;
			if (kick_q) begin
				fin_occ_q <= count_q - expired;
				fin_earliest_q <= rest_valid ? rest_exp : '0;
			end else begin
				fin_occ_q <= count_q;
				fin_earliest_q <= (rest_valid && rest_exp < due_q) ? rest_exp : due_q;
			end
		end
		if (cmd.op == OP_POP) pops_left_q <= pops_left_q - CNT_W'(1);
		if (emit) begin
			status <= r_status;
			out_conn <= r_conn;
			out_sequence <= r_seq;
			out_expiry <= r_exp;
			removed_count <= r_removed;
			earliest <= r_earliest;
			occupancy <= r_occ;
			last <= r_last;
		end
	end

endmodule

// ----- hw/rtl/heartbeat_timer_queue.sv -----
// top level of the heartbeat timer queue
// A request is taken when start is high and busy is low; its results follow on
// consecutive cycles, each shown for one cycle with done high, the final one with
// last high, and the receiver cannot stall them. An add or clear gives one result,
// a delete removes every matching entry, one a cycle, before its one result, and a tick
// drops or re-arms one head of the sorted chain a cycle, each with a result.
// Configuration writes are always ready and belong between requests.
module heartbeat_timer_queue import hbtq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] kind,
	input logic [CONN_W-1:0] conn_id,
	input logic [SEQ_W-1:0] sequence_req,
	input logic [TIME_W-1:0] now,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [0:0] cfg_index,
	input logic [WAIT_W-1:0] cfg_data,
	output logic done,
	output logic [2:0] status,
	output logic [CONN_W-1:0] out_conn,
	output logic [SEQ_W-1:0] out_sequence,
	output logic [TIME_W-1:0] out_expiry,
	output logic [CNT_W-1:0] removed_count,
	output logic [TIME_W-1:0] earliest,
	output logic [CNT_W-1:0] occupancy,
	output logic last
);

	cmd_t cmd;
	stat_t st;

	assign cfg_ready = 1'b1;

	hbtq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .kind(kind),
		.st(st), .cmd(cmd), .busy(busy)
	);

	hbtq_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.conn_id(conn_id), .sequence_req(sequence_req), .now(now),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .status(status), .out_conn(out_conn),
		.out_sequence(out_sequence), .out_expiry(out_expiry),
		.removed_count(removed_count), .earliest(earliest),
		.occupancy(occupancy), .last(last)
	);

endmodule

// ----- hw/rtl/hbtq_checker.sv -----
// port level checks of the heartbeat timer queue
module hbtq_checker import hbtq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic [2:0] status,
	input logic [TIME_W-1:0] earliest,
	input logic [CNT_W-1:0] occupancy,
	input logic last
);

	// a taken request keeps the block busy in the next cycle
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("request not held busy");

	// the final result leaves the block idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done && last |-> !busy) else $error("busy after final result");

	// only expired entries come in runs
	a_multi: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |-> status == STAT_EXPIRED) else $error("bad result run");

	// a clear leaves nothing behind
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == STAT_CLEARED |-> occupancy == '0 && earliest == '0)
		else $error("clear left entries");

	a_occ: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> occupancy <= CNT_W'(QUEUE_DEPTH)) else $error("occupancy too large");

endmodule

bind heartbeat_timer_queue hbtq_checker u_hbtq_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.status(status), .earliest(earliest), .occupancy(occupancy), .last(last)
);

// ----- tb/heartbeat_timer_queue_check.sv -----
// checker: predicts the timer queue results and compares them with the block's output
`timescale 1ns / 100ps
module heartbeat_timer_queue_check import hbtq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic [1:0] kind,
	input logic [CONN_W-1:0] conn_id,
	input logic [SEQ_W-1:0] sequence_req,
	input logic [TIME_W-1:0] now,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [0:0] cfg_index,
	input logic [WAIT_W-1:0] cfg_data,
	input logic done,
	input logic [2:0] status,
	input logic [CONN_W-1:0] out_conn,
	input logic [SEQ_W-1:0] out_sequence,
	input logic [TIME_W-1:0] out_expiry,
	input logic [CNT_W-1:0] removed_count,
	input logic [TIME_W-1:0] earliest,
	input logic [CNT_W-1:0] occupancy,
	input logic last,
	output int failures,
	output int pending
);

	typedef struct {
		logic [2:0] status;
		logic [CONN_W-1:0] conn;
		logic [SEQ_W-1:0] seq;
		logic [TIME_W-1:0] expiry;
		logic [CNT_W-1:0] removed;
		logic [TIME_W-1:0] earliest;
		logic [CNT_W-1:0] occupancy;
		logic last;
	} timer_result_t;

	timer_result_t results_due[$];
	entry_t slots[QUEUE_DEPTH];
	int fill;
	logic [WAIT_W-1:0] wait_s;
	logic kick;

	function automatic logic [TIME_W-1:0] deadline(logic [TIME_W-1:0] t);
		logic [TIME_W:0] sum;
		sum = {1'b0, t} + {17'b0, wait_s};
		return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
	endfunction

	// stable insert: goes after every entry with equal expiry
	function automatic bit place(entry_t e);
		int pos;
		pos = 0;
		if (fill >= QUEUE_DEPTH)
			return 0;
		while (pos < fill && slots[pos].expiry <= e.expiry)
			pos++;
		for (int i = fill; i > pos; i--)
			slots[i] = slots[i - 1];
		slots[pos] = e;
		fill++;
		return 1;
	endfunction

	function automatic void take_out(int pos);
		for (int i = pos; i + 1 < fill; i++)
			slots[i] = slots[i + 1];
		fill--;
	endfunction

	function automatic void note(logic [2:0] st, entry_t e, logic [CNT_W-1:0] rm);
		timer_result_t r;
		r.status = st;
		r.conn = e.conn;
		r.seq = e.seq;
		r.expiry = e.expiry;
		r.removed = rm;
		r.earliest = 0;
		r.occupancy = 0;
		r.last = 0;
		results_due.insert(results_due.size(), r);
	endfunction

	function automatic void predict_request();
		entry_t blank;
		entry_t e;
		int first;
		int expired;
		int removed;
		blank = '0;
		first = results_due.size();
		case (kind)
			KIND_ADD: begin
				e.expiry = deadline(now);
				e.conn = conn_id;
				e.seq = sequence_req;
				note(place(e) ? STAT_ADDED : STAT_FULL, blank, 0);
			end
			KIND_DEL: begin
				removed = 0;
				for (int i = 0; i < fill; ) begin
					if (slots[i].conn == conn_id) begin
						take_out(i);
						removed++;
					end else begin
						i++;
					end
				end
				note(STAT_DELETED, blank, removed[CNT_W-1:0]);
			end
			KIND_TICK: begin
				expired = 0;
				while (expired < fill && slots[expired].expiry <= now)
					expired++;
				if (expired > MAX_RESULTS)
					expired = MAX_RESULTS;
				if (expired == 0)
					note(STAT_NONE, blank, 0);
				for (int i = 0; i < expired; i++) begin
					e = slots[0];
					take_out(0);
					note(STAT_EXPIRED, e, 0);
					if (!kick) begin
						e.expiry = deadline(now);
						void'(place(e));
					end
				end
			end
			default: begin
				fill = 0;
				note(STAT_CLEARED, blank, 0);
			end
		endcase
		// queue summary fields reflect the state after the whole request
		for (int k = first; k < results_due.size(); k++) begin
			results_due[k].earliest = fill > 0 ? slots[0].expiry : '0;
			results_due[k].occupancy = fill[CNT_W-1:0];
			results_due[k].last = (k == results_due.size() - 1);
		end
	endfunction

	function automatic void check_field(string name, logic [TIME_W-1:0] want,
			logic [TIME_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			failures++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		timer_result_t w;
		if (!arst_n) begin
			results_due.delete();
			fill = 0;
			wait_s = 20;
			kick = 0;
			failures = 0;
			pending = 0;
		end else begin
			if (done) begin
				if (results_due.size() == 0) begin
					$error("result with status %0d arrived with nothing expected", status);
					failures++;
				end else begin
					w = results_due[0];
					results_due.delete(0);
					check_field("status", w.status, status);
					check_field("out_conn", w.conn, out_conn);
					check_field("out_sequence", w.seq, out_sequence);
					check_field("out_expiry", w.expiry, out_expiry);
					check_field("removed_count", w.removed, removed_count);
					check_field("earliest", w.earliest, earliest);
					check_field("occupancy", w.occupancy, occupancy);
					check_field("last", w.last, last);
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_WAIT)
					wait_s = cfg_data;
				else
					kick = cfg_data[0];
			end
			if (start && !busy)
				predict_request();
			pending = results_due.size();
		end
	end

endmodule

// ----- tb/heartbeat_timer_queue_test.sv -----
// testbench top: stimulus for the timer queue, checker hookup and verdict
`timescale 1ns / 100ps
module heartbeat_timer_queue_test;
	import hbtq_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [1:0] kind = KIND_ADD;
	logic [CONN_W-1:0] conn_id = 0;
	logic [SEQ_W-1:0] sequence_req = 0;
	logic [TIME_W-1:0] now = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [0:0] cfg_index = CFG_WAIT;
	logic [WAIT_W-1:0] cfg_data = 0;
	logic done;
	logic [2:0] status;
	logic [CONN_W-1:0] out_conn;
	logic [SEQ_W-1:0] out_sequence;
	logic [TIME_W-1:0] out_expiry;
	logic [CNT_W-1:0] removed_count;
	logic [TIME_W-1:0] earliest;
	logic [CNT_W-1:0] occupancy;
	logic last;
	int failures;
	int pending;
	int quiet_cycles = 0;
	logic [TIME_W-1:0] clock_base = 1000;
	logic [WAIT_W-1:0] cur_wait = 20;

	always #6 clk = ~clk;

	heartbeat_timer_queue DUT (.*);
	heartbeat_timer_queue_check checker_i (.*);

	// watchdog on cycles without any handshake or result
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// drive one request and hold it until taken, then drop start and idle if gap is nonzero
	task automatic request(logic [1:0] k, logic [CONN_W-1:0] c, logic [SEQ_W-1:0] s,
			logic [TIME_W-1:0] t, int gap);
		start <= 1;
		kind <= k;
		conn_id <= c;
		sequence_req <= s;
		now <= t;
		forever begin
			@(negedge clk);
			if (!busy)
				break;
		end
		@(posedge clk);
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		start <= 0;
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [WAIT_W-1:0] v);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		forever begin
			@(negedge clk);
			if (cfg_ready)
				break;
		end
		@(posedge clk);
		cfg_valid <= 0;
		if (idx == CFG_WAIT)
			cur_wait = v;
		@(posedge clk);
	endtask

	// mostly small connection ids so deletes find entries
	function automatic logic [CONN_W-1:0] pick_conn();
		return CONN_W'(($urandom_range(0, 9) < 8) ? $urandom_range(0, 7) : $urandom());
	endfunction

	function automatic logic [TIME_W-1:0] pick_time();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return $urandom();
		if (r < 7)
			return '1 - $urandom_range(0, 70000);
		return clock_base;
	endfunction

	task automatic random_phase(int count);
		int r;
		logic [1:0] k;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			k = r < 50 ? KIND_ADD : r < 65 ? KIND_DEL : r < 96 ? KIND_TICK : KIND_CLR;
			if ($urandom_range(0, 3) == 0)
				clock_base += $urandom_range(0, cur_wait);
			request(k, pick_conn(), $urandom(), pick_time(), pick_gap());
		end
		settle();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed part: equal expiries, full queue, saturation, all request kinds
		request(KIND_TICK, 0, 0, 0, 0);
		request(KIND_ADD, 16'hFFFF, '1, 100, 0);
		request(KIND_ADD, 16'h0000, 0, 100, 1);
		request(KIND_ADD, 16'h0001, 32'h5555_AAAA, 50, 0);
		request(KIND_TICK, 0, 0, 119, 0);
		request(KIND_TICK, 0, 0, 120, 2);
		request(KIND_DEL, 16'hFFFF, 0, 0, 0);
		request(KIND_DEL, 16'h1234, 0, 0, 0);
		request(KIND_ADD, 3, 32'hAAAA_5555, '1, 0);
		request(KIND_TICK, 0, 0, '1, 0);
		request(KIND_CLR, 0, 0, 0, 0);
		settle();
		write_reg(CFG_WAIT, 16'hFFFF);
		for (int i = 0; i < QUEUE_DEPTH + 2; i++)
			request(KIND_ADD, CONN_W'(i % 4), SEQ_W'(i), TIME_W'(32'hFFFF_0000 - i), 0);
		request(KIND_TICK, 0, 0, '1, 0);
		request(KIND_DEL, 2, 0, 0, 0);
		settle();
		write_reg(CFG_KICK, 1);
		request(KIND_TICK, 0, 0, '1, 0);
		request(KIND_CLR, 0, 0, 0, 0);
		settle();

		// random phases across register settings, extremes included
		write_reg(CFG_WAIT, 1);
		write_reg(CFG_KICK, 0);
		random_phase(45);
		write_reg(CFG_WAIT, 30);
		random_phase(45);
		write_reg(CFG_KICK, 1);
		random_phase(50);
		write_reg(CFG_WAIT, WAIT_W'($urandom_range(1, 65535)));
		write_reg(CFG_KICK, 0);
		random_phase(50);
		write_reg(CFG_WAIT, 16'hFFFF);
		random_phase(30);

		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
